// ----- sv/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg: shared definitions for the bounded dynamic array
// Command and status codes, field widths, stream packing and the response
// record passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int BDA_CAPACITY = 1024;
  localparam int BDA_ELEM_W   = 32;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 10;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 11;
  localparam int ST_W   = 2;

  localparam int S_FIELDS_W = CMD_W + POS_W + DATA_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = DATA_W + LEN_W + ST_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic              load;       // result ready and output register free
    logic              use_rdata;  // data_out comes from the RAM read port
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;
  } bda_resp_t;

endpackage

// ----- sv/bda_ram.sv -----
// ----------------------------------------------------------------------------
// bda_ram: generic single-port RAM
// One address per cycle for write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module bda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- sv/bda_alu.sv -----
// ----------------------------------------------------------------------------
// bda_alu: shared subtract and compare unit
// Gives lhs - rhs, lhs >= rhs and lhs == rhs for unsigned operands.
// ----------------------------------------------------------------------------
module bda_alu #(
  parameter int OPW = 11
) (
  input  logic [OPW-1:0] lhs,
  input  logic [OPW-1:0] rhs,
  output logic [OPW-1:0] diff,
  output logic           ge,
  output logic           eq
);

  logic [OPW:0] full_diff;

  assign full_diff = {1'b0, lhs} - {1'b0, rhs};
  assign diff      = full_diff[OPW-1:0];
  assign ge        = ~full_diff[OPW];
  assign eq        = (lhs == rhs);

endmodule

// ----- sv/bda_ctrl.sv -----
// ----------------------------------------------------------------------------
// bda_ctrl: command sequencer
// Holds the element count, runs each command through the shared compare
// unit and drives the element RAM, including the zero-fill sweep for a set
// past the current length.
// ----------------------------------------------------------------------------
module bda_ctrl
  import bda_pkg::*;
#(
  parameter int CAPACITY      = BDA_CAPACITY,
  parameter int ELEMENT_WIDTH = BDA_ELEM_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [CMD_W-1:0]            req_cmd,
  input  logic [POS_W-1:0]            req_pos,
  input  logic [ELEMENT_WIDTH-1:0]    req_val,
  input  logic                        out_free,
  output bda_resp_t                   resp,
  output logic                        ram_we,
  output logic                        ram_re,
  output logic [$clog2(CAPACITY)-1:0] ram_addr,
  output logic [ELEMENT_WIDTH-1:0]    ram_wdata
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int OPW  = (CNTW > POS_W) ? CNTW : POS_W;

  localparam logic [OPW-1:0] CAP_OP = OPW'(CAPACITY);
  localparam logic [OPW-1:0] ONE_OP = OPW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]               state, state_next;
  logic [CNTW-1:0]          count, count_next;
  logic [ST_W-1:0]          status, status_next;
  logic                     use_rd, use_rd_next;
  logic [CMD_W-1:0]         cmd;
  logic [POS_W-1:0]         pos;
  logic [ELEMENT_WIDTH-1:0] val;

  logic [OPW-1:0] lhs, rhs, diff;
  logic           ge, eq;
  logic [OPW-1:0] pos_op, count_op;

  assign pos_op   = OPW'(pos);
  assign count_op = OPW'(count);

  bda_alu #(.OPW(OPW)) u_alu (
    .lhs  (lhs),
    .rhs  (rhs),
    .diff (diff),
    .ge   (ge),
    .eq   (eq)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = status;
    use_rd_next = use_rd;
    lhs         = '0;
    rhs         = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = AW'(count);
    ram_wdata   = val;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next  = S_RESP;
        status_next = ST_OK;
        use_rd_next = 1'b0;
        unique case (cmd)
          CMD_PUSH: begin
            lhs = count_op;
            rhs = CAP_OP;
            if (ge) begin
              status_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              count_next = count + CNTW'(1);
            end
          end
          CMD_POP: begin
            lhs = count_op;
            rhs = ONE_OP;
            if (!ge) begin
              status_next = ST_EMPTY;
            end else begin
              // diff is count - 1: both the new top and the read address
              ram_re      = 1'b1;
              ram_addr    = AW'(diff);
              count_next  = CNTW'(diff);
              use_rd_next = 1'b1;
            end
          end
          CMD_GET: begin
            lhs = pos_op;
            rhs = count_op;
            if (ge) begin
              status_next = ST_RANGE;
            end else begin
              ram_re      = 1'b1;
              ram_addr    = AW'(pos);
              use_rd_next = 1'b1;
            end
          end
          CMD_SET: begin
            lhs = pos_op;
            rhs = CAP_OP;
            if (ge) begin
              status_next = ST_FULL;
            end else begin
              state_next = S_FILL;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_FILL: begin
        lhs = pos_op;
        rhs = count_op;
        if (!ge) begin
          // position already inside the array
          ram_we     = 1'b1;
          ram_addr   = AW'(pos);
          state_next = S_RESP;
        end else if (eq) begin
          ram_we     = 1'b1;
          ram_addr   = AW'(pos);
          count_next = count + CNTW'(1);
          state_next = S_RESP;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = '0;
          count_next = count + CNTW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      status <= ST_OK;
      use_rd <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      status <= status_next;
      use_rd <= use_rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd <= req_cmd;
      pos <= req_pos;
      val <= req_val;
    end
  end

  assign req_ready      = (state == S_IDLE);
  assign resp.load      = (state == S_RESP) && out_free;
  assign resp.use_rdata = use_rd;
  assign resp.status    = status;
  assign resp.length    = LEN_W'(count);

endmodule

// ----- sv/bounded_dynamic_array_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_dynamic_array_unit: fixed-capacity array with a stack top
// Push, pop, get and set requests on a stream port; one result per request.
// ----------------------------------------------------------------------------
// Sequence: push, pop and get pass through the execute and response states;
// set adds a fill state that writes the value and zero-fills the entries
// below its position when it lands past the length (one RAM write per cycle
// through the single RAM port). Requests: one at a time, a new one taken
// the cycle after the previous result is handed to the output register.
// Reset: count and handshake state clear; array contents stay undefined.
module bounded_dynamic_array_unit
  import bda_pkg::*;
#(
  parameter int CAPACITY      = BDA_CAPACITY,
  parameter int ELEMENT_WIDTH = BDA_ELEM_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // command, position, data_in, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // data_out, length, status, zero pad
);

  localparam int AW = $clog2(CAPACITY);

  logic [CMD_W-1:0]         in_cmd;
  logic [POS_W-1:0]         in_pos;
  logic [DATA_W-1:0]        in_data;
  logic [ELEMENT_WIDTH-1:0] in_val;

  bda_resp_t                resp;
  logic                     out_free;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_addr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [DATA_W-1:0] out_data;
  logic [LEN_W-1:0]  out_len;
  logic [ST_W-1:0]   out_status;

  assign in_cmd  = s_tdata[CMD_W-1:0];
  assign in_pos  = s_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_data = s_tdata[S_FIELDS_W-1:CMD_W+POS_W];
  assign in_val  = ELEMENT_WIDTH'(in_data);

  assign out_free = !m_tvalid || m_tready;

  bda_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_cmd   (in_cmd),
    .req_pos   (in_pos),
    .req_val   (in_val),
    .out_free  (out_free),
    .resp      (resp),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  bda_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (resp.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // read values are sign-extended from the element width, then cut to 32 bits
  always_ff @(posedge clk) begin
    if (resp.load) begin
      out_data   <= resp.use_rdata ? DATA_W'($signed(ram_rdata)) : '0;
      out_len    <= resp.length;
      out_status <= resp.status;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_status, out_len, out_data};

  assert property (@(posedge clk) disable iff (rst)
    resp.load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending output");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in progress");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != ST_OK) |-> (out_data == '0))
    else $error("nonzero data on a flagged result");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_EMPTY) |-> (out_len == '0))
    else $error("empty pop reported with nonzero length");

endmodule
